/* rtl/u2cp_pkg.sv */
package u2cp_pkg;

	// Values of the text_encoding register. Codes above ENC_UTF32_BIG decode as UTF-8.
	localparam logic [2:0] ENC_UTF8         = 3'd0;
	localparam logic [2:0] ENC_UTF16_LITTLE = 3'd1;
	localparam logic [2:0] ENC_UTF16_BIG    = 3'd2;
	localparam logic [2:0] ENC_UTF32_LITTLE = 3'd3;
	localparam logic [2:0] ENC_UTF32_BIG    = 3'd4;

	localparam logic [15:0] BOM_POINT      = 16'hFEFF;
	localparam logic [20:0] SUPPLEMENT_BASE = 21'h10000;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_of_text;
	} byte_item_t;

	typedef struct packed {
		logic [31:0] code_point;
		logic        end_of_text;
	} point_item_t;

	// One step of the decoder: whether the byte completed a result, and the result.
	typedef struct packed {
		logic        valid;
		point_item_t item;
	} step_res_t;

endpackage

/* rtl/u2cp_core.sv */
module u2cp_core
	import u2cp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step_en,
	input  byte_item_t  step_item,
	input  logic [2:0]  encoding,
	output step_res_t   res
);

	logic [1:0]  byte_count_q;
	logic [31:0] unit_value_q;
	logic [1:0]  bytes_needed_q;
	logic [20:0] partial_q;
	logic [9:0]  high_sur_q;
	logic        sur_pending_q;
	logic        first_pending_q;
	logic        ended_q;

	logic [1:0]  byte_count_d;
	logic [31:0] unit_value_d;
	logic [1:0]  bytes_needed_d;
	logic [20:0] partial_d;
	logic [9:0]  high_sur_d;
	logic        sur_pending_d;
	logic        first_pending_d;
	logic        ended_d;

	always_comb begin
		logic [1:0]  bc;
		logic [31:0] uv;
		logic [1:0]  bn;
		logic [20:0] pp;
		logic [9:0]  hs;
		logic        sp;
		logic        fp;
		logic        te;
		logic [2:0]  width;
		logic        big;
		logic [31:0] unit;
		logic [7:0]  c;
		logic [15:0] u;
		logic [31:0] pt;
		logic        have;
		logic [4:0]  sh;
		logic [20:0] cont;

		bc = byte_count_q;
		uv = unit_value_q;
		bn = bytes_needed_q;
		pp = partial_q;
		hs = high_sur_q;
		sp = sur_pending_q;
		fp = first_pending_q;
		te = ended_q;
		if (step_item.start_of_text) begin
			bc = '0;
			uv = '0;
			bn = '0;
			pp = '0;
			hs = '0;
			sp = 1'b0;
			fp = 1'b1;
			te = 1'b0;
		end

		res = '0;
		pt = '0;
		have = 1'b0;
		unit = '0;
		c = '0;
		u = '0;
		sh = '0;
		cont = '0;

		case (encoding)
			ENC_UTF16_LITTLE, ENC_UTF16_BIG: width = 3'd2;
			ENC_UTF32_LITTLE, ENC_UTF32_BIG: width = 3'd4;
			default: width = 3'd1;
		endcase
		big = (encoding == ENC_UTF16_BIG) || (encoding == ENC_UTF32_BIG);

		if (!te) begin
			if (big) begin
				uv = {uv[23:0], step_item.data_byte};
			end else begin
				uv = uv | (32'(step_item.data_byte) << {bc, 3'b000});
			end

			if ({1'b0, bc} + 3'd1 < width) begin
				bc = bc + 2'd1;
			end else begin
				unit = uv;
				uv = '0;
				bc = '0;
				if (unit == '0) begin
					// A zero code unit terminates the text and drops partial state.
					bn = '0;
					pp = '0;
					sp = 1'b0;
					hs = '0;
					te = 1'b1;
					res.valid = 1'b1;
					res.item.end_of_text = 1'b1;
				end else begin
					if (width == 3'd2) begin
						u = unit[15:0];
						if (sp) begin
							pt = {11'b0, {1'b0, hs, u[9:0]} + SUPPLEMENT_BASE};
							sp = 1'b0;
							hs = '0;
							have = 1'b1;
						end else if (u[15:11] == 5'b11011) begin
							hs = u[9:0];
							sp = 1'b1;
						end else begin
							pt = {16'b0, u};
							have = 1'b1;
						end
					end else if (width == 3'd4) begin
						pt = unit;
						have = 1'b1;
					end else begin
						c = unit[7:0];
						if (bn != 2'd0) begin
							case (bn)
								2'd2: sh = 5'd6;
								2'd3: sh = 5'd12;
								default: sh = 5'd0;
							endcase
							cont = 21'(c ^ 8'h80) << sh;
							pp = pp | cont;
							bn = bn - 2'd1;
							if (bn == 2'd0) begin
								pt = {11'b0, pp};
								pp = '0;
								have = 1'b1;
							end
						end else if (c[7] == 1'b0) begin
							pt = {24'b0, c};
							have = 1'b1;
						end else if (c[7:5] == 3'b110) begin
							pp = 21'(c ^ 8'hC0) << 6;
							bn = 2'd1;
						end else if (c[7:4] == 4'b1110) begin
							pp = 21'(c ^ 8'hE0) << 12;
							bn = 2'd2;
						end else if (c[7:3] == 5'b11110) begin
							pp = 21'(c ^ 8'hF0) << 18;
							bn = 2'd3;
						end else begin
							// Stray continuation or invalid lead byte.
							pt = '0;
							have = 1'b1;
						end
					end

					if (have) begin
						res.valid = 1'b1;
						res.item.code_point = pt;
						if (fp) begin
							fp = 1'b0;
							if (pt == {16'b0, BOM_POINT}) begin
								res.valid = 1'b0;
							end
						end
					end
				end
			end
		end

		if (!step_en) begin
			res.valid = 1'b0;
		end

		byte_count_d = bc;
		unit_value_d = uv;
		bytes_needed_d = bn;
		partial_d = pp;
		high_sur_d = hs;
		sur_pending_d = sp;
		first_pending_d = fp;
		ended_d = te;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			unit_value_q <= '0;
			bytes_needed_q <= '0;
			partial_q <= '0;
			high_sur_q <= '0;
			sur_pending_q <= 1'b0;
			first_pending_q <= 1'b1;
			ended_q <= 1'b0;
		end else if (step_en) begin
			byte_count_q <= byte_count_d;
			unit_value_q <= unit_value_d;
			bytes_needed_q <= bytes_needed_d;
			partial_q <= partial_d;
			high_sur_q <= high_sur_d;
			sur_pending_q <= sur_pending_d;
			first_pending_q <= first_pending_d;
			ended_q <= ended_d;
		end
	end

endmodule

/* rtl/unicode_to_code_point_decoder.sv */
// Text decoder: raw bytes of a UTF-8, UTF-16 or UTF-32 text in, code points out.
// Byte channel (byte_valid, byte_ready, byte_item) takes one byte per item;
// start_of_text on an item clears all decoder state before that byte is used.
// Point channel (point_valid, point_ready, point_item) delivers at most one
// code point per byte; a zero code unit yields point 0 with end_of_text set,
// after which bytes are taken and dropped until the next start_of_text.
// Configuration channel (cfg_valid, cfg_ready, cfg_data) writes the 3-bit
// encoding; it is always ready and must only be written while the block is idle.
// Path: the last byte of a code point waits in the input register, is decoded
// combinationally and is registered in the output register, which offers it.
// Throughput: one byte per cycle while the receiver does not stall, set by the
// single decode step between the input register and the output register;
// the decoder state updates once per byte.
// When the receiver stalls, the output register holds its item and the input
// register holds the next byte; byte_ready drops only when both are full.
// Reset clears the encoding to UTF-8 and the decoder to the start of a text.
module unicode_to_code_point_decoder
	import u2cp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_ready,
	input  byte_item_t  byte_item,
	output logic        point_valid,
	input  logic        point_ready,
	output point_item_t point_item,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_data
);

	logic [2:0]  encoding_q;
	logic        valid_s1;
	byte_item_t  item_s1;
	logic        valid_s2;
	point_item_t item_s2;
	logic        advance;
	step_res_t   res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			encoding_q <= ENC_UTF8;
		end else if (cfg_valid && cfg_ready) begin
			encoding_q <= cfg_data;
		end
	end

	assign advance    = valid_s1 && (!valid_s2 || point_ready);
	assign byte_ready = !valid_s1 || !valid_s2 || point_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			item_s1 <= byte_item;
		end
	end

	u2cp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (advance),
		.step_item (item_s1),
		.encoding  (encoding_q),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || point_ready) begin
			valid_s2 <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			item_s2 <= res.item;
		end
	end

	assign point_valid = valid_s2;
	assign point_item  = item_s2;

endmodule

/* rtl/u2cp_checker.sv */
module u2cp_checker
	import u2cp_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        byte_valid,
	input logic        byte_ready,
	input byte_item_t  byte_item,
	input logic        point_valid,
	input logic        point_ready,
	input point_item_t point_item
);

	// A waiting byte item keeps its value until it is taken.
	a_byte_hold: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && !byte_ready |=> byte_valid && $stable(byte_item))
		else $error("byte item changed while waiting");

	// A stalled result keeps its value.
	a_point_hold: assert property (@(posedge clk) disable iff (!arst_n)
		point_valid && !point_ready |=> point_valid && $stable(point_item))
		else $error("result item changed while stalled");

	// The end-of-text item always carries code point zero.
	a_end_zero: assert property (@(posedge clk) disable iff (!arst_n)
		point_valid && point_item.end_of_text |-> point_item.code_point == 32'd0)
		else $error("end-of-text item with nonzero code point");

	// An empty output only fills from an accepted byte that passed through the input register and the output register.
	a_rise_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(point_valid) |-> $past(byte_valid && byte_ready, 2))
		else $error("result item without an accepted byte");

endmodule

bind unicode_to_code_point_decoder u2cp_checker u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.byte_valid  (byte_valid),
	.byte_ready  (byte_ready),
	.byte_item   (byte_item),
	.point_valid (point_valid),
	.point_ready (point_ready),
	.point_item  (point_item)
);
